FILE: rtl/upr_pkg.sv
`timescale 1ns / 1ps
// upr_pkg: field widths, command and status codes and CRC constants
// for the update packet receiver; no dependencies

package upr_pkg;

  // field widths
  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int OFFSET_W  = 14;
  localparam int STATUS_W  = 3;
  localparam int LENGTH_W  = 15;
  localparam int CRC_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam int REG_DAT_W = 25;
  localparam int MS_W      = 16;
  localparam int SLOT_W    = 25;

  // command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // final status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC    = 3'd4;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_TMO = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT     = 2'd2;

  // register reset values
  localparam logic [MS_W-1:0]   WINDOW_RST   = 16'd3000;
  localparam logic [MS_W-1:0]   BYTE_TMO_RST = 16'd1000;
  localparam logic [SLOT_W-1:0] SLOT_RST     = 25'd65536;

  // framing constants
  localparam logic [31:0]    SYNC_WORD     = 32'h4855_5031;
  localparam logic [32:0]    SLOT_HEADROOM = 33'd4096;
  localparam logic [7:0]     VERSION_OK    = 8'd1;
  localparam logic [CRC_W-1:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [MS_W-1:0]  MS_MAX      = 16'hFFFF;

endpackage

FILE: rtl/upr_in_if.sv
`timescale 1ns / 1ps
// upr_in_if: input item channel (command and received byte)
// depends on upr_pkg for field widths

interface upr_in_if;
  logic                        valid;
  logic                        ready;
  logic [upr_pkg::CMD_W-1:0]   cmd;
  logic [upr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

FILE: rtl/upr_out_if.sv
`timescale 1ns / 1ps
// upr_out_if: result item channel (payload bytes and final status)
// depends on upr_pkg for field widths

interface upr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [upr_pkg::OFFSET_W-1:0]  offset;
  logic [upr_pkg::BYTE_W-1:0]    payload_byte;
  logic [upr_pkg::STATUS_W-1:0]  status;
  logic [upr_pkg::LENGTH_W-1:0]  length;
  logic [upr_pkg::CRC_W-1:0]     computed_crc;

  modport source (output valid, output kind, output offset, output payload_byte,
                  output status, output length, output computed_crc, input ready);
  modport sink   (input valid, input kind, input offset, input payload_byte,
                  input status, input length, input computed_crc, output ready);
endinterface

FILE: rtl/upr_cfg_if.sv
`timescale 1ns / 1ps
// upr_cfg_if: configuration write channel (register index and data)
// depends on upr_pkg for field widths

interface upr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [upr_pkg::REG_IDX_W-1:0]   index;
  logic [upr_pkg::REG_DAT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/upr_crc8.sv
`timescale 1ns / 1ps
// upr_crc8: one-byte update of a reflected CRC-32, unrolled into an xor network
// depends on upr_pkg for the polynomial

module upr_crc8 (
  input  logic [upr_pkg::CRC_W-1:0]  crc_in,
  input  logic [upr_pkg::BYTE_W-1:0] data,
  output logic [upr_pkg::CRC_W-1:0]  crc_out
);
  import upr_pkg::*;

  // eight shift steps, lsb first
  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    crc_out = c;
  end

endmodule

FILE: rtl/uart_update_packet_receiver.sv
`timescale 1ns / 1ps
// uart_update_packet_receiver: sync-word hunt, header parse and crc-checked
// payload streaming; depends on upr_pkg, upr_in_if, upr_out_if, upr_cfg_if, upr_crc8
//
//  channel  | dir  | carries                                   | handshake
//  events   | in   | cmd, rx_byte                              | valid/ready
//  results  | out  | kind, offset, payload_byte, status,       | valid/ready
//           |      | length, computed_crc                      |
//  cfg      | in   | index, data (register write)              | valid/ready
//
// one item per cycle while events.ready is high: the session state and the result
// register are updated in the cycle the item is taken; the crc byte network and
// the 32-bit compares set the path. a result appears in the cycle after its item.
// events.ready drops only while a result is held and results.ready is low.
// rst is synchronous and restores the register defaults and an idle session.
// cfg writes are always ready.

module uart_update_packet_receiver #(
  parameter int MAX_PAYLOAD = 16384
) (
  input  logic       clk,
  input  logic       rst,
  upr_in_if.sink     events,
  upr_out_if.source  results,
  upr_cfg_if.sink    cfg
);
  import upr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HUNT       = 3'd1;
  localparam logic [2:0] PH_HDR        = 3'd2;
  localparam logic [2:0] PH_HDR_BADVER = 3'd3;
  localparam logic [2:0] PH_PAY        = 3'd4;

  // configuration registers
  logic [MS_W-1:0]   hunt_limit;
  logic [MS_W-1:0]   byte_timeout_ms;
  logic [SLOT_W-1:0] slot_size;

  // session state
  logic [2:0]       phase, phase_next;
  logic [23:0]      sync_window, sync_window_next;
  logic [MS_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [MS_W-1:0]  gap_ms, gap_ms_next;
  logic [3:0]       header_index, header_index_next;
  logic [31:0]      declared_length, declared_length_next;
  logic [CRC_W-1:0] expected_crc, expected_crc_next;
  logic [CNT_W-1:0] bytes_received, bytes_received_next;
  logic [CRC_W-1:0] running_crc, running_crc_next;

  // result register
  logic                out_valid;
  logic                kind;
  logic [OFFSET_W-1:0] offset;
  logic [BYTE_W-1:0]   payload_byte;
  logic [STATUS_W-1:0] status;
  logic [LENGTH_W-1:0] length;
  logic [CRC_W-1:0]    computed_crc;

  // result of the current item
  logic                emit;
  logic                res_kind;
  logic [OFFSET_W-1:0] res_offset;
  logic [BYTE_W-1:0]   res_byte;
  logic [STATUS_W-1:0] res_status;
  logic [LENGTH_W-1:0] res_length;
  logic [CRC_W-1:0]    res_crc;

  logic             take;
  logic [CRC_W-1:0] crc_upd;
  logic [CRC_W-1:0] crc_fin;
  logic [LENGTH_W-1:0] len_sat;
  logic [31:0]      hunt_word;
  logic [MS_W-1:0]  elapsed_inc;
  logic [MS_W-1:0]  gap_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic             len_bad;

  assign take           = events.valid && events.ready;
  assign events.ready   = !out_valid || results.ready;
  assign cfg.ready      = 1'b1;

  assign results.valid        = out_valid;
  assign results.kind         = kind;
  assign results.offset       = offset;
  assign results.payload_byte = payload_byte;
  assign results.status       = status;
  assign results.length       = length;
  assign results.computed_crc = computed_crc;

  // payload crc byte update
  upr_crc8 u_crc (
    .crc_in  (running_crc),
    .data    (events.rx_byte),
    .crc_out (crc_upd)
  );

  assign crc_fin     = ~crc_upd;
  assign len_sat     = (declared_length > 32'h7FFF) ? 15'h7FFF : declared_length[14:0];
  assign hunt_word   = {sync_window, events.rx_byte};
  assign elapsed_inc = (elapsed_ms < MS_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign gap_inc     = (gap_ms < MS_MAX) ? gap_ms + 16'd1 : gap_ms;
  assign cnt_inc     = bytes_received + CNT_W'(1);
  assign len_bad     = (declared_length == 32'd0) ||
                       (declared_length > 32'(MAX_PAYLOAD)) ||
                       ({1'b0, declared_length} + SLOT_HEADROOM > 33'(slot_size));

  // session next state and result
  always_comb begin
    phase_next           = phase;
    sync_window_next     = sync_window;
    elapsed_ms_next      = elapsed_ms;
    gap_ms_next          = gap_ms;
    header_index_next    = header_index;
    declared_length_next = declared_length;
    expected_crc_next    = expected_crc;
    bytes_received_next  = bytes_received;
    running_crc_next     = running_crc;
    emit       = 1'b0;
    res_kind   = 1'b1;
    res_offset = '0;
    res_byte   = '0;
    res_status = ST_OK;
    res_length = '0;
    res_crc    = '0;

    if (events.cmd == CMD_START) begin
      // restart the session from scratch
      phase_next           = PH_HUNT;
      sync_window_next     = '0;
      elapsed_ms_next      = '0;
      gap_ms_next          = '0;
      header_index_next    = '0;
      declared_length_next = '0;
      expected_crc_next    = '0;
      bytes_received_next  = '0;
      running_crc_next     = CRC_INIT;
      if (hunt_limit == '0) begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
        res_status = ST_TIMEOUT;
      end
    end else if (phase != PH_IDLE && events.cmd == CMD_TICK) begin
      if (phase == PH_HUNT) begin
        // hunt window count
        elapsed_ms_next = elapsed_inc;
        if (elapsed_inc >= hunt_limit) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          res_status = ST_TIMEOUT;
        end
      end else begin
        // gap between header or payload bytes
        gap_ms_next = gap_inc;
        if (gap_inc >= byte_timeout_ms) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          if (phase == PH_PAY) begin
            res_status = ST_BAD_LENGTH;
            res_length = len_sat;
          end else begin
            res_status = ST_BAD_HEADER;
          end
        end
      end
    end else if (phase != PH_IDLE && events.cmd == CMD_BYTE) begin
      case (phase)
        PH_HUNT: begin
          if (elapsed_ms >= hunt_limit) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            res_status = ST_TIMEOUT;
          end else begin
            sync_window_next = hunt_word[23:0];
            if (hunt_word == SYNC_WORD) begin
              phase_next           = PH_HDR;
              header_index_next    = '0;
              gap_ms_next          = '0;
              declared_length_next = '0;
              expected_crc_next    = '0;
            end
          end
        end
        PH_HDR, PH_HDR_BADVER: begin
          gap_ms_next       = '0;
          header_index_next = header_index + 4'd1;
          case (header_index)
            4'd0: if (events.rx_byte != VERSION_OK) phase_next = PH_HDR_BADVER;
            4'd2: declared_length_next[7:0]   = declared_length[7:0]   | events.rx_byte;
            4'd3: declared_length_next[15:8]  = declared_length[15:8]  | events.rx_byte;
            4'd4: declared_length_next[23:16] = declared_length[23:16] | events.rx_byte;
            4'd5: declared_length_next[31:24] = declared_length[31:24] | events.rx_byte;
            4'd6: expected_crc_next[7:0]      = expected_crc[7:0]      | events.rx_byte;
            4'd7: expected_crc_next[15:8]     = expected_crc[15:8]     | events.rx_byte;
            4'd8: expected_crc_next[23:16]    = expected_crc[23:16]    | events.rx_byte;
            4'd9: expected_crc_next[31:24]    = expected_crc[31:24]    | events.rx_byte;
            default: ;
          endcase
          // header complete: check version and length
          if (header_index >= 4'd9) begin
            if (phase == PH_HDR_BADVER) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              res_status = ST_BAD_HEADER;
            end else if (len_bad) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              res_status = ST_BAD_LENGTH;
              res_length = len_sat;
            end else begin
              phase_next          = PH_PAY;
              bytes_received_next = '0;
              running_crc_next    = CRC_INIT;
            end
          end
        end
        PH_PAY: begin
          gap_ms_next         = '0;
          running_crc_next    = crc_upd;
          bytes_received_next = cnt_inc;
          emit       = 1'b1;
          res_offset = OFFSET_W'(bytes_received);
          res_byte   = events.rx_byte;
          res_length = len_sat;
          if (32'(cnt_inc) >= declared_length) begin
            // last payload byte carries the final status
            phase_next = PH_IDLE;
            res_status = (crc_fin == expected_crc) ? ST_OK : ST_BAD_CRC;
            res_crc    = crc_fin;
          end else begin
            res_kind = 1'b0;
          end
        end
        default: begin
          gap_ms_next = '0;
          phase_next  = PH_IDLE;
        end
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit      <= WINDOW_RST;
      byte_timeout_ms <= BYTE_TMO_RST;
      slot_size       <= SLOT_RST;
      phase           <= PH_IDLE;
      sync_window     <= '0;
      elapsed_ms      <= '0;
      gap_ms          <= '0;
      header_index    <= '0;
      declared_length <= '0;
      expected_crc    <= '0;
      bytes_received  <= '0;
      running_crc     <= CRC_INIT;
      out_valid       <= 1'b0;
    end else begin
      // configuration writes
      if (cfg.valid) begin
        case (cfg.index)
          REG_WINDOW:   hunt_limit      <= cfg.data[MS_W-1:0];
          REG_BYTE_TMO: byte_timeout_ms <= cfg.data[MS_W-1:0];
          REG_SLOT:     slot_size       <= cfg.data[SLOT_W-1:0];
          default: ;
        endcase
      end
      // session state advances on every taken item
      if (take) begin
        phase           <= phase_next;
        sync_window     <= sync_window_next;
        elapsed_ms      <= elapsed_ms_next;
        gap_ms          <= gap_ms_next;
        header_index    <= header_index_next;
        declared_length <= declared_length_next;
        expected_crc    <= expected_crc_next;
        bytes_received  <= bytes_received_next;
        running_crc     <= running_crc_next;
      end
      // result valid
      if (results.ready) out_valid <= 1'b0;
      if (take && emit) out_valid <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind         <= res_kind;
      offset       <= res_offset;
      payload_byte <= res_byte;
      status       <= res_status;
      length       <= res_length;
      computed_crc <= res_crc;
    end
  end

endmodule
